// ----- rtl/fcdm_pkg.sv -----
package fcdm_pkg;

	localparam int NUM_FAULTS = 6;
	localparam int OCC_BITS = 16;
	localparam int OCC_OUT_W = 16;
	localparam int DEB_W = 4;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_INDEX_W = 3;

	localparam logic [DEB_W-1:0] DEBOUNCE_MAX = '1;
	localparam logic [OCC_BITS-1:0] OCC_MAX = '1;
	localparam logic [11:0] BELT_MIN_SPEED = 12'd10;

	// fault numbering
	localparam int F_OVERHEAT = 0;
	localparam int F_BATTERY = 1;
	localparam int F_OVERSPEED = 2;
	localparam int F_TIRE = 3;
	localparam int F_DOOR = 4;
	localparam int F_BELT = 5;

	typedef enum logic [1:0] {
		ST_NONE      = 2'd0,
		ST_PENDING   = 2'd1,
		ST_CONFIRMED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_EVALUATE  = 2'd0,
		CMD_CLEAR_ALL = 2'd1,
		CMD_CLEAR_ONE = 2'd2,
		CMD_QUERY     = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEMP_CRITICAL    = 3'd0,
		REG_VOLT_LOW         = 3'd1,
		REG_OVERSPEED_LIMIT  = 3'd2,
		REG_PSI_LOW          = 3'd3,
		REG_DOOR_SPEED_LIMIT = 3'd4,
		REG_CONFIRM_COUNT    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [11:0] temp;
		logic [10:0]        volt;
		logic [11:0]        speed;
		logic [9:0]         psi;
		logic               door;
		logic               belt;
	} frame_t;

endpackage

// ----- rtl/fault_code_debounce_monitor.sv -----
// the accepted sample word is held in the sample register, and its result word is offered
// from the result register; throughput: one word per cycle while result_ready is high;
// the two registers form a two-stage path with all fault bookkeeping done in one pass between them
// reset: arst_n clears all fault records, counts and freeze frames, loads the
// threshold registers with their defaults and empties both stages
module fault_code_debounce_monitor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_write,
	input  logic [fcdm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fcdm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// sample channel
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [1:0]                           command,
	input  logic [2:0]                           fault_index,
	input  logic signed [11:0]                   temp,
	input  logic [10:0]                          volt,
	input  logic [11:0]                          speed,
	input  logic [9:0]                           psi,
	input  logic                                 door_open,
	input  logic                                 belt_locked,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic                                 mil_on,
	output logic [2:0]                           active_count,
	output logic [2:0]                           confirmed_count,
	output logic [5:0]                           newly_confirmed,
	output logic [1:0]                           fault_status,
	output logic [15:0]                          occurrence_count,
	output logic signed [11:0]                   frozen_temp,
	output logic [10:0]                          frozen_volt,
	output logic [11:0]                          frozen_speed,
	output logic [9:0]                           frozen_psi,
	output logic                                 frozen_door,
	output logic                                 frozen_belt
);

	localparam int NF = fcdm_pkg::NUM_FAULTS;
	localparam int OCC_EXT_W = fcdm_pkg::OCC_BITS + fcdm_pkg::OCC_OUT_W;

	// ------------------------------------------------------------------
	// threshold registers
	// ------------------------------------------------------------------
	logic signed [11:0] temp_critical_q;
	logic [10:0]        volt_low_q;
	logic [11:0]        overspeed_limit_q;
	logic [9:0]         psi_low_q;
	logic [11:0]        door_speed_limit_q;
	logic [3:0]         confirm_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_critical_q    <= 12'sd1100;
			volt_low_q         <= 11'd1150;
			overspeed_limit_q  <= 12'd1200;
			psi_low_q          <= 10'd250;
			door_speed_limit_q <= 12'd50;
			confirm_count_q    <= 4'd3;
		end else if (cfg_write) begin
			// indexes past the register list are dropped
			case (cfg_index)
				fcdm_pkg::REG_TEMP_CRITICAL:    temp_critical_q    <= $signed(cfg_data[11:0]);
				fcdm_pkg::REG_VOLT_LOW:         volt_low_q         <= cfg_data[10:0];
				fcdm_pkg::REG_OVERSPEED_LIMIT:  overspeed_limit_q  <= cfg_data[11:0];
				fcdm_pkg::REG_PSI_LOW:          psi_low_q          <= cfg_data[9:0];
				fcdm_pkg::REG_DOOR_SPEED_LIMIT: door_speed_limit_q <= cfg_data[11:0];
				fcdm_pkg::REG_CONFIRM_COUNT:    confirm_count_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage 1: sample register
	// ------------------------------------------------------------------
	logic                 valid_s1;
	fcdm_pkg::cmd_t       cmd_s1;
	logic [2:0]           idx_s1;
	fcdm_pkg::frame_t     smp_s1;
	logic                 advance;

	// stage 1 moves on whenever the result register is empty or being drained
	assign advance      = valid_s1 && (!result_valid || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			cmd_s1       <= fcdm_pkg::cmd_t'(command);
			idx_s1       <= fault_index;
			smp_s1.temp  <= temp;
			smp_s1.volt  <= volt;
			smp_s1.speed <= speed;
			smp_s1.psi   <= psi;
			smp_s1.door  <= door_open;
			smp_s1.belt  <= belt_locked;
		end
	end

	// ------------------------------------------------------------------
	// fault records
	// ------------------------------------------------------------------
	logic [fcdm_pkg::DEB_W-1:0]    deb_q    [NF];
	fcdm_pkg::status_t             status_q [NF];
	logic [fcdm_pkg::OCC_BITS-1:0] occ_q    [NF];
	fcdm_pkg::frame_t              frame_q  [NF];

	logic [fcdm_pkg::DEB_W-1:0]    deb_n    [NF];
	fcdm_pkg::status_t             status_n [NF];
	logic [fcdm_pkg::OCC_BITS-1:0] occ_n    [NF];
	fcdm_pkg::frame_t              frame_n  [NF];

	logic [NF-1:0] fault_hit;
	logic [NF-1:0] newly;
	logic [2:0]    act_cnt;
	logic [2:0]    conf_cnt;

	// fault predicates on the registered sample
	always_comb begin
		fault_hit = '0;
		fault_hit[fcdm_pkg::F_OVERHEAT]  = smp_s1.temp >= temp_critical_q;
		fault_hit[fcdm_pkg::F_BATTERY]   = smp_s1.volt < volt_low_q;
		fault_hit[fcdm_pkg::F_OVERSPEED] = smp_s1.speed > overspeed_limit_q;
		fault_hit[fcdm_pkg::F_TIRE]      = smp_s1.psi < psi_low_q;
		fault_hit[fcdm_pkg::F_DOOR]      = smp_s1.door && (smp_s1.speed > door_speed_limit_q);
		// belt warning only once the car is rolling at 1.0 km/h or more
		fault_hit[fcdm_pkg::F_BELT]      = !smp_s1.belt &&
		                                   (smp_s1.speed >= fcdm_pkg::BELT_MIN_SPEED);
	end

	// next record values; each fault is independent of the others
	always_comb begin
		logic [fcdm_pkg::DEB_W-1:0]    deb_inc;
		logic [fcdm_pkg::OCC_BITS-1:0] occ_base;
		fcdm_pkg::status_t             st_mid;
		fcdm_pkg::frame_t              frm_mid;
		deb_inc  = '0;
		occ_base = '0;
		st_mid   = fcdm_pkg::ST_NONE;
		frm_mid  = '0;
		newly    = '0;
		for (int i = 0; i < NF; i++) begin
			deb_n[i]    = deb_q[i];
			status_n[i] = status_q[i];
			occ_n[i]    = occ_q[i];
			frame_n[i]  = frame_q[i];
			unique case (cmd_s1)
				fcdm_pkg::CMD_EVALUATE: begin
					if (!fault_hit[i]) begin
						// healed: only the debounce count goes back to zero
						deb_n[i] = '0;
					end else begin
						deb_inc = (deb_q[i] == fcdm_pkg::DEBOUNCE_MAX) ?
						          deb_q[i] : deb_q[i] + 1'b1;
						// a fault with no record opens a fresh pending one
						if (status_q[i] == fcdm_pkg::ST_NONE) begin
							st_mid   = fcdm_pkg::ST_PENDING;
							occ_base = '0;
							frm_mid  = '0;
						end else begin
							st_mid   = status_q[i];
							occ_base = occ_q[i];
							frm_mid  = frame_q[i];
						end
						deb_n[i]    = deb_inc;
						occ_n[i]    = (occ_base == fcdm_pkg::OCC_MAX) ?
						              occ_base : occ_base + 1'b1;
						status_n[i] = st_mid;
						frame_n[i]  = frm_mid;
						if (deb_inc >= confirm_count_q && st_mid == fcdm_pkg::ST_PENDING) begin
							status_n[i] = fcdm_pkg::ST_CONFIRMED;
							frame_n[i]  = smp_s1;
							newly[i]    = 1'b1;
						end
					end
				end
				fcdm_pkg::CMD_CLEAR_ALL: begin
					status_n[i] = fcdm_pkg::ST_NONE;
					deb_n[i]    = '0;
				end
				fcdm_pkg::CMD_CLEAR_ONE: begin
					// an index of 6 or 7 matches no fault
					if (idx_s1 == 3'(i)) begin
						status_n[i] = fcdm_pkg::ST_NONE;
						deb_n[i]    = '0;
					end
				end
				fcdm_pkg::CMD_QUERY: ;
			endcase
		end
	end

	// summary counts over the updated records
	always_comb begin
		act_cnt  = '0;
		conf_cnt = '0;
		for (int i = 0; i < NF; i++) begin
			act_cnt  = act_cnt + 3'(status_n[i] != fcdm_pkg::ST_NONE);
			conf_cnt = conf_cnt + 3'(status_n[i] == fcdm_pkg::ST_CONFIRMED);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NF; i++) begin
				deb_q[i]    <= '0;
				status_q[i] <= fcdm_pkg::ST_NONE;
				occ_q[i]    <= '0;
				frame_q[i]  <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < NF; i++) begin
				deb_q[i]    <= deb_n[i];
				status_q[i] <= status_n[i];
				occ_q[i]    <= occ_n[i];
				frame_q[i]  <= frame_n[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// selected record, read after the command has acted
	// ------------------------------------------------------------------
	logic                 sel_ok;
	fcdm_pkg::status_t    sel_status;
	logic [OCC_EXT_W-1:0] sel_occ_ext;
	fcdm_pkg::frame_t     sel_frame;

	assign sel_ok = idx_s1 < 3'(NF);

	always_comb begin
		sel_status  = fcdm_pkg::ST_NONE;
		sel_occ_ext = '0;
		sel_frame   = '0;
		if (sel_ok) begin
			sel_status  = status_n[idx_s1];
			sel_occ_ext = OCC_EXT_W'(occ_n[idx_s1]);
			sel_frame   = frame_n[idx_s1];
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || result_ready) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mil_on           <= conf_cnt != 3'd0;
			active_count     <= act_cnt;
			confirmed_count  <= conf_cnt;
			newly_confirmed  <= newly;
			fault_status     <= sel_status;
			occurrence_count <= sel_occ_ext[fcdm_pkg::OCC_OUT_W-1:0];
			frozen_temp      <= sel_frame.temp;
			frozen_volt      <= sel_frame.volt;
			frozen_speed     <= sel_frame.speed;
			frozen_psi       <= sel_frame.psi;
			frozen_door      <= sel_frame.door;
			frozen_belt      <= sel_frame.belt;
		end
	end

endmodule

// ----- test/tb.sv -----
module tb;

	// one sample word as offered on the input channel
	typedef struct packed {
		fcdm_pkg::cmd_t   cmd;
		logic [2:0]       idx;
		fcdm_pkg::frame_t frm;
	} sample_t;

	// one result word as seen on the output channel
	typedef struct packed {
		logic                           mil;
		logic [2:0]                     active;
		logic [2:0]                     confirmed;
		logic [5:0]                     newly;
		fcdm_pkg::status_t              status;
		logic [fcdm_pkg::OCC_OUT_W-1:0] occ;
		fcdm_pkg::frame_t               frm;
	} report_t;

	// keeps a private copy of the fault records and thresholds, predicts each report
	class dtc_scoreboard;
		logic signed [11:0]            temp_crit;
		logic [10:0]                   volt_low;
		logic [11:0]                   overspeed;
		logic [9:0]                    psi_low;
		logic [11:0]                   door_speed;
		logic [3:0]                    confirm;
		logic [fcdm_pkg::DEB_W-1:0]    debounce [fcdm_pkg::NUM_FAULTS];
		fcdm_pkg::status_t             status [fcdm_pkg::NUM_FAULTS];
		logic [fcdm_pkg::OCC_BITS-1:0] occurrences [fcdm_pkg::NUM_FAULTS];
		fcdm_pkg::frame_t              freeze [fcdm_pkg::NUM_FAULTS];
		report_t                       predicted [$];
		int                            mismatches;

		function new();
			int i;
			temp_crit = 12'sd1100;
			volt_low = 11'd1150;
			overspeed = 12'd1200;
			psi_low = 10'd250;
			door_speed = 12'd50;
			confirm = 4'd3;
			for (i = 0; i < fcdm_pkg::NUM_FAULTS; i++) begin
				debounce[i] = '0;
				status[i] = fcdm_pkg::ST_NONE;
				occurrences[i] = '0;
				freeze[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void write_reg(fcdm_pkg::reg_index_t r, logic [11:0] d);
			case (r)
				fcdm_pkg::REG_TEMP_CRITICAL:    temp_crit = d;
				fcdm_pkg::REG_VOLT_LOW:         volt_low = d[10:0];
				fcdm_pkg::REG_OVERSPEED_LIMIT:  overspeed = d;
				fcdm_pkg::REG_PSI_LOW:          psi_low = d[9:0];
				fcdm_pkg::REG_DOOR_SPEED_LIMIT: door_speed = d;
				fcdm_pkg::REG_CONFIRM_COUNT:    confirm = d[3:0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			logic [fcdm_pkg::NUM_FAULTS-1:0] hit;
			report_t r;
			int i;
			hit[fcdm_pkg::F_OVERHEAT] = $signed(s.frm.temp) >= $signed(temp_crit);
			hit[fcdm_pkg::F_BATTERY] = s.frm.volt < volt_low;
			hit[fcdm_pkg::F_OVERSPEED] = s.frm.speed > overspeed;
			hit[fcdm_pkg::F_TIRE] = s.frm.psi < psi_low;
			hit[fcdm_pkg::F_DOOR] = s.frm.door && (s.frm.speed > door_speed);
			hit[fcdm_pkg::F_BELT] = !s.frm.belt && (s.frm.speed >= fcdm_pkg::BELT_MIN_SPEED);
			r = '0;
			case (s.cmd)
				fcdm_pkg::CMD_EVALUATE: begin
					for (i = 0; i < fcdm_pkg::NUM_FAULTS; i++) begin
						if (!hit[i]) begin
							debounce[i] = '0;
						end else begin
							if (debounce[i] != fcdm_pkg::DEBOUNCE_MAX)
								debounce[i]++;
							if (status[i] == fcdm_pkg::ST_NONE) begin
								status[i] = fcdm_pkg::ST_PENDING;
								occurrences[i] = '0;
								freeze[i] = '0;
							end
							if (occurrences[i] != fcdm_pkg::OCC_MAX)
								occurrences[i]++;
							if (debounce[i] >= confirm &&
							    status[i] == fcdm_pkg::ST_PENDING) begin
								status[i] = fcdm_pkg::ST_CONFIRMED;
								freeze[i] = s.frm;
								r.newly[i] = 1'b1;
							end
						end
					end
				end
				fcdm_pkg::CMD_CLEAR_ALL: begin
					for (i = 0; i < fcdm_pkg::NUM_FAULTS; i++) begin
						status[i] = fcdm_pkg::ST_NONE;
						debounce[i] = '0;
					end
				end
				fcdm_pkg::CMD_CLEAR_ONE: begin
					if (s.idx < fcdm_pkg::NUM_FAULTS) begin
						status[s.idx] = fcdm_pkg::ST_NONE;
						debounce[s.idx] = '0;
					end
				end
				default: ;
			endcase
			for (i = 0; i < fcdm_pkg::NUM_FAULTS; i++) begin
				if (status[i] != fcdm_pkg::ST_NONE)
					r.active++;
				if (status[i] == fcdm_pkg::ST_CONFIRMED)
					r.confirmed++;
			end
			r.mil = (r.confirmed != 0);
			if (s.idx < fcdm_pkg::NUM_FAULTS) begin
				r.status = status[s.idx];
				r.occ = occurrences[s.idx][fcdm_pkg::OCC_OUT_W-1:0];
				r.frm = freeze[s.idx];
			end
			predicted.insert(predicted.size(), r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %0d, got %0d", name, want, seen);
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (predicted.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with no sample outstanding");
				return;
			end
			want = predicted[0];
			predicted.delete(0);
			compare_field("mil_on", 16'(want.mil), 16'(got.mil));
			compare_field("active_count", 16'(want.active), 16'(got.active));
			compare_field("confirmed_count", 16'(want.confirmed), 16'(got.confirmed));
			compare_field("newly_confirmed", 16'(want.newly), 16'(got.newly));
			compare_field("fault_status", 16'(want.status), 16'(got.status));
			compare_field("occurrence_count", want.occ, got.occ);
			compare_field("frozen_temp", 16'(want.frm.temp), 16'(got.frm.temp));
			compare_field("frozen_volt", 16'(want.frm.volt), 16'(got.frm.volt));
			compare_field("frozen_speed", 16'(want.frm.speed), 16'(got.frm.speed));
			compare_field("frozen_psi", 16'(want.frm.psi), 16'(got.frm.psi));
			compare_field("frozen_door", 16'(want.frm.door), 16'(got.frm.door));
			compare_field("frozen_belt", 16'(want.frm.belt), 16'(got.frm.belt));
		endfunction

		function bit failed();
			return mismatches != 0 || predicted.size() != 0;
		endfunction
	endclass

	// cycles with no word moving on either channel before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// evaluate words in the closing run that holds the belt fault active
	localparam int BELT_HOLD_WORDS = 8;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [11:0]        cfg_data;
	logic               sample_valid;
	logic               sample_ready;
	logic [1:0]         command;
	logic [2:0]         fault_index;
	logic signed [11:0] temp;
	logic [10:0]        volt;
	logic [11:0]        speed;
	logic [9:0]         psi;
	logic               door_open;
	logic               belt_locked;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               mil_on;
	logic [2:0]         active_count;
	logic [2:0]         confirmed_count;
	logic [5:0]         newly_confirmed;
	logic [1:0]         fault_status;
	logic [15:0]        occurrence_count;
	logic signed [11:0] frozen_temp;
	logic [10:0]        frozen_volt;
	logic [11:0]        frozen_speed;
	logic [9:0]         frozen_psi;
	logic               frozen_door;
	logic               frozen_belt;

	dtc_scoreboard sb;
	bit calm = 1'b0;		// set for a stretch in which neither side idles
	int idle_cycles = 0;

	fault_code_debounce_monitor uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.command(command),
		.fault_index(fault_index),
		.temp(temp),
		.volt(volt),
		.speed(speed),
		.psi(psi),
		.door_open(door_open),
		.belt_locked(belt_locked),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.mil_on(mil_on),
		.active_count(active_count),
		.confirmed_count(confirmed_count),
		.newly_confirmed(newly_confirmed),
		.fault_status(fault_status),
		.occurrence_count(occurrence_count),
		.frozen_temp(frozen_temp),
		.frozen_volt(frozen_volt),
		.frozen_speed(frozen_speed),
		.frozen_psi(frozen_psi),
		.frozen_door(frozen_door),
		.frozen_belt(frozen_belt)
	);

	always #5 clk = ~clk;

	// everything is observed at the rising edge, before the design's own updates land
	always @(posedge clk) begin
		sample_t s;
		report_t r;
		if (arst_n) begin
			if (cfg_write)
				sb.write_reg(fcdm_pkg::reg_index_t'(cfg_index), cfg_data);
			// older words leave first, so check the result before noting the new sample
			if (result_valid && result_ready) begin
				r.mil = mil_on;
				r.active = active_count;
				r.confirmed = confirmed_count;
				r.newly = newly_confirmed;
				r.status = fcdm_pkg::status_t'(fault_status);
				r.occ = occurrence_count;
				r.frm.temp = frozen_temp;
				r.frm.volt = frozen_volt;
				r.frm.speed = frozen_speed;
				r.frm.psi = frozen_psi;
				r.frm.door = frozen_door;
				r.frm.belt = frozen_belt;
				sb.check_report(r);
			end
			if (sample_valid && sample_ready) begin
				s.cmd = fcdm_pkg::cmd_t'(command);
				s.idx = fault_index;
				s.frm.temp = temp;
				s.frm.volt = volt;
				s.frm.speed = speed;
				s.frm.psi = psi;
				s.frm.door = door_open;
				s.frm.belt = belt_locked;
				sb.note_sample(s);
			end
			// watchdog: any word moving on either side restarts the count
			if ((result_valid && result_ready) || (sample_valid && sample_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	// result side back-pressure, changed only at the falling edge
	always @(negedge clk) begin
		result_ready = calm || ($urandom_range(0, 99) >= 11);
	end

	// a value close to a threshold, a value anywhere in the working range, or raw bits
	function automatic logic [11:0] near_mark(int mark, int lo, int hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 12'(mark + int'($urandom_range(0, 6)) - 3);
		else if (roll < 95)
			return 12'(lo + int'($urandom_range(0, hi - lo)));
		else
			return 12'($urandom);
	endfunction

	function automatic fcdm_pkg::frame_t pick_frame();
		fcdm_pkg::frame_t f;
		logic [11:0] v;
		int speed_mark;
		case ($urandom_range(0, 2))
			0: speed_mark = int'(sb.overspeed);
			1: speed_mark = int'(sb.door_speed);
			default: speed_mark = int'(fcdm_pkg::BELT_MIN_SPEED);
		endcase
		f.temp = near_mark(int'(sb.temp_crit), -400, 1500);
		v = near_mark(int'(sb.volt_low), 0, 2000);
		f.volt = v[10:0];
		f.speed = near_mark(speed_mark, 0, 3000);
		v = near_mark(int'(sb.psi_low), 0, 1000);
		f.psi = v[9:0];
		f.door = 1'($urandom);
		f.belt = 1'($urandom);
		return f;
	endfunction

	// offers one sample word, starting and ending at a falling edge
	task automatic send_word(sample_t s);
		while (!calm && $urandom_range(0, 99) < 11) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		command = s.cmd;
		fault_index = s.idx;
		temp = s.frm.temp;
		volt = s.frm.volt;
		speed = s.frm.speed;
		psi = s.frm.psi;
		door_open = s.frm.door;
		belt_locked = s.frm.belt;
		sample_valid = 1'b1;
		do
			@(posedge clk);
		while (!sample_ready);
		@(negedge clk);
	endtask

	task automatic offer(fcdm_pkg::cmd_t c, int idx, int t, int v, int sp, int p, int d, int b);
		sample_t s;
		s.cmd = c;
		s.idx = idx[2:0];
		s.frm.temp = t[11:0];
		s.frm.volt = v[10:0];
		s.frm.speed = sp[11:0];
		s.frm.psi = p[9:0];
		s.frm.door = d[0];
		s.frm.belt = b[0];
		send_word(s);
	endtask

	// sender holds off until every outstanding result word has been taken
	task automatic drain();
		sample_valid = 1'b0;
		while (sb.predicted.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_reg(fcdm_pkg::reg_index_t r, logic [11:0] d);
		cfg_write = 1'b1;
		cfg_index = r;
		cfg_data = d;
		@(negedge clk);
	endtask

	// thresholds are only touched with the pipeline empty
	task automatic set_thresholds(int t, int v, int o, int p, int d, int c);
		drain();
		program_reg(fcdm_pkg::REG_TEMP_CRITICAL, t[11:0]);
		program_reg(fcdm_pkg::REG_VOLT_LOW, v[11:0]);
		program_reg(fcdm_pkg::REG_OVERSPEED_LIMIT, o[11:0]);
		program_reg(fcdm_pkg::REG_PSI_LOW, p[11:0]);
		program_reg(fcdm_pkg::REG_DOOR_SPEED_LIMIT, d[11:0]);
		program_reg(fcdm_pkg::REG_CONFIRM_COUNT, c[11:0]);
		cfg_write = 1'b0;
	endtask

	// episodes hold one sample for a while so faults debounce and confirm,
	// with fresh samples, queries and clears mixed in
	task automatic run_traffic(int count);
		sample_t s;
		fcdm_pkg::frame_t base;
		int left;
		int run;
		int pick;
		left = count;
		while (left > 0) begin
			base = pick_frame();
			run = $urandom_range(1, 24);
			while (run > 0 && left > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 84)
					s.cmd = fcdm_pkg::CMD_EVALUATE;
				else if (pick < 91)
					s.cmd = fcdm_pkg::CMD_QUERY;
				else if (pick < 96)
					s.cmd = fcdm_pkg::CMD_CLEAR_ONE;
				else
					s.cmd = fcdm_pkg::CMD_CLEAR_ALL;
				if ($urandom_range(0, 99) < 8)
					s.idx = 3'($urandom_range(6, 7));
				else
					s.idx = 3'($urandom_range(0, fcdm_pkg::NUM_FAULTS - 1));
				s.frm = ($urandom_range(0, 99) < 75) ? base : pick_frame();
				send_word(s);
				run--;
				left--;
			end
		end
	endtask

	initial begin
		sample_t s;
		int n;
		sb = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		command = '0;
		fault_index = '0;
		temp = '0;
		volt = '0;
		speed = '0;
		psi = '0;
		door_open = 1'b0;
		belt_locked = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words at the reset thresholds
		// untouched record, then nothing active
		offer(fcdm_pkg::CMD_QUERY, fcdm_pkg::F_OVERHEAT, 0, 1200, 0, 300, 0, 1);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_BATTERY, 0, 1200, 0, 300, 0, 1);
		// all six pending, then all confirm together, then already confirmed
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_OVERHEAT, 1500, 0, 3000, 0, 1, 0);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_TIRE, 1500, 0, 3000, 0, 1, 0);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_BELT, 1500, 0, 3000, 0, 1, 0);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_DOOR, 1500, 0, 3000, 0, 1, 0);
		// index past the last fault
		offer(fcdm_pkg::CMD_QUERY, 6, 0, 0, 0, 0, 0, 0);
		offer(fcdm_pkg::CMD_QUERY, 7, 0, 0, 0, 0, 0, 0);
		// record kept after clear; an index of 7 clears nothing
		offer(fcdm_pkg::CMD_CLEAR_ONE, fcdm_pkg::F_OVERSPEED, 0, 0, 0, 0, 0, 0);
		offer(fcdm_pkg::CMD_CLEAR_ONE, 7, 0, 0, 0, 0, 0, 0);
		offer(fcdm_pkg::CMD_QUERY, fcdm_pkg::F_OVERSPEED, 0, 0, 0, 0, 0, 0);
		// just inside the temperature, voltage, speed and pressure limits, then just over with a fresh record
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_OVERSPEED, 1099, 1150, 1200, 250, 1, 1);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_OVERSPEED, 1100, 1149, 1201, 249, 0, 0);
		// pending shows a blank frame
		offer(fcdm_pkg::CMD_QUERY, fcdm_pkg::F_OVERSPEED, 0, 0, 0, 0, 0, 0);
		// belt below and at its speed floor
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_BELT, -400, 2000, 9, 1000, 1, 0);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_BELT, -400, 2000, 10, 1000, 0, 0);
		// door just over and at its limit
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_DOOR, -400, 2000, 51, 1000, 1, 1);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_DOOR, -400, 2000, 50, 1000, 1, 1);
		// cleared, old frame still there
		offer(fcdm_pkg::CMD_CLEAR_ALL, fcdm_pkg::F_OVERHEAT, 0, 0, 0, 0, 0, 0);
		offer(fcdm_pkg::CMD_QUERY, fcdm_pkg::F_OVERHEAT, 0, 0, 0, 0, 0, 0);
		// all bits at their limits
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_TIRE, -2048, 2047, 4095, 1023, 1, 0);
		offer(fcdm_pkg::CMD_EVALUATE, fcdm_pkg::F_TIRE, 2047, 0, 0, 0, 0, 1);

		// threshold settings, extremes first; every change waits for an empty pipeline
		set_thresholds(-400, 0, 0, 0, 0, 1);
		run_traffic(165);
		set_thresholds(1500, 2000, 3000, 1000, 3000, 15);
		run_traffic(165);
		set_thresholds(int'($urandom_range(0, 1900)) - 400, $urandom_range(0, 2000),
			$urandom_range(0, 3000), $urandom_range(0, 1000), $urandom_range(0, 3000), 0);
		run_traffic(165);
		set_thresholds(-2048, 2047, 4095, 1023, 4095, 2);
		run_traffic(165);
		set_thresholds(2047, 1150, 1200, 250, 50, 0);
		run_traffic(165);
		// a stretch with both sides going flat out
		calm = 1'b1;
		set_thresholds(1100, 1150, 1200, 250, 50, 3);
		run_traffic(165);
		calm = 1'b0;
		set_thresholds(int'($urandom_range(0, 1900)) - 400, $urandom_range(0, 2000),
			$urandom_range(0, 3000), $urandom_range(0, 1000), $urandom_range(0, 3000),
			$urandom_range(1, 15));
		run_traffic(165);
		set_thresholds(int'($urandom_range(0, 1900)) - 400, $urandom_range(0, 2000),
			$urandom_range(0, 3000), $urandom_range(0, 1000), $urandom_range(0, 3000),
			$urandom_range(1, 15));
		run_traffic(165);

		// belt fault held active without a break
		set_thresholds(1100, 1150, 1200, 250, 50, 4);
		for (n = 0; n < BELT_HOLD_WORDS; n++) begin
			s.cmd = fcdm_pkg::CMD_EVALUATE;
			s.idx = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) :
			        3'(fcdm_pkg::F_BELT);
			s.frm = pick_frame();
			s.frm.belt = 1'b0;
			if (s.frm.speed < fcdm_pkg::BELT_MIN_SPEED)
				s.frm.speed = fcdm_pkg::BELT_MIN_SPEED + 12'($urandom_range(0, 3));
			send_word(s);
		end

		drain();
		repeat (8) @(negedge clk);
		if (!sb.failed()) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// ----- fault_code_debounce_monitor.f -----
rtl/fcdm_pkg.sv
rtl/fault_code_debounce_monitor.sv
test/tb.sv
